// File: hw/rtl/pkba_pkg.sv
// ----------------------------------------------------------------------------
// pkba_pkg: shared types for the paged KV block allocator
// Item layouts, result codes, register indexes, FSM states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pkba_pkg;

  localparam int KIND_W     = 2;
  localparam int SEQ_W      = 8;
  localparam int TOK_W      = 20;
  localparam int SLOT_W     = 8;
  localparam int COUNT_W    = 7;
  localparam int PHYS_W     = 10;
  localparam int ADDR_W     = 64;
  localparam int BB_W       = 32;
  localparam int CFG_DATA_W = 64;

  localparam logic [BB_W-1:0] BLOCK_BYTES_RESET = 32'd262144;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_FREE   = 2'd2,
    KIND_LOOKUP = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    RS_OK        = 3'd0,
    RS_BAD_SEQ   = 3'd1,
    RS_ALREADY   = 3'd2,
    RS_NOT_ALLOC = 3'd3,
    RS_NO_BLOCKS = 3'd4,
    RS_BAD_SLOT  = 3'd5
  } status_e;

  typedef enum logic [0:0] {
    REG_KV_BASE     = 1'b0,
    REG_BLOCK_BYTES = 1'b1
  } reg_e;

  typedef struct packed {
    kind_e              kind;
    logic [SEQ_W-1:0]   seq_id;
    logic [TOK_W-1:0]   tok_count;
    logic [SLOT_W-1:0]  slot_index;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [COUNT_W-1:0] block_count;
    logic [PHYS_W-1:0]  phys_block;
    logic [ADDR_W-1:0]  block_address;
  } rsp_t;

  typedef struct packed {
    reg_e                  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_POP_RD,
    ST_POP_WR,
    ST_DRAIN_RD,
    ST_DRAIN_WR,
    ST_LK_MUL,
    ST_LK_ADD,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    CNT_ZERO,
    CNT_IDX,
    CNT_SEQ
  } cnt_sel_e;

  typedef struct packed {
    logic     load;
    logic     check;
    logic     pop_wr;
    logic     rb_init;
    logic     drain_rd;
    logic     drain_wr;
    logic     lk_rd;
    logic     lk_mul;
    logic     lk_add;
    logic     cnt_wr;
    logic     cnt_wr_zero;
    logic     fin;
    status_e  status;
    cnt_sel_e cnt_sel;
    logic     lk_res;
  } cmd_t;

  typedef struct packed {
    logic  bad_seq;
    kind_e kind;
    logic  cnt_zero;
    logic  lk_ok;
    logic  fill_done;
    logic  top_zero;
    logic  drain_done;
    logic  out_busy;
  } stat_t;

endpackage

// File: hw/rtl/pkba_chan_if.sv
// ----------------------------------------------------------------------------
// pkba_chan_if: valid/ready channel
// Generic handshake channel carrying one payload item of type T.
// ----------------------------------------------------------------------------
interface pkba_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/paged_kv_block_allocator.sv
// ----------------------------------------------------------------------------
// paged_kv_block_allocator: paged KV-cache block allocator
// Hands out physical cache blocks to sequences from a free stack and
// resolves a sequence slot to its block number and byte address.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  : request items (allocate, append, free, lookup) by valid/ready.
//   rsp_o  : one result item per request, held in an output register.
//   cfg_i  : register writes (kv base address, block bytes), always ready;
//            write only while no request is in flight.
// Steps: a rejected request or bad sequence goes from check straight to the
// result; a lookup reads the slot table, multiplies and adds; allocate and
// append pop blocks (up to the slots per sequence) until the tokens are
// covered; running out of blocks gives the popped blocks back; free drains
// the sequence's blocks onto the free stack. Each block moved takes one
// registered memory read, then the write into the slot table or free
// stack. One request is worked at a time; the next is taken once the
// result sits in the output register, so a stalled receiver holds back at
// most one finished result.
// Reset: free stack reads as full (block i at entry i, via a low-water mark),
// all sequence counts zero, registers at their reset values. No clear pass.
// ----------------------------------------------------------------------------
module paged_kv_block_allocator #(
  parameter int NUM_SEQUENCES      = 16,
  parameter int SLOTS_PER_SEQUENCE = 64,
  parameter int PHYS_BLOCKS        = 1024,
  parameter int TOKENS_PER_BLOCK   = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  pkba_chan_if.sink        req_i,
  pkba_chan_if.source      rsp_o,
  pkba_chan_if.sink        cfg_i
);

  pkba_pkg::cmd_t  cmd;
  pkba_pkg::stat_t stat;
  logic            req_ready;

  assign req_i.ready = req_ready;
  // register writes are never stalled
  assign cfg_i.ready = 1'b1;

  pkba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pkba_dp #(
    .NumSequences     (NUM_SEQUENCES),
    .SlotsPerSequence (SLOTS_PER_SEQUENCE),
    .TotalBlocks      (PHYS_BLOCKS),
    .TokensPerBlock   (TOKENS_PER_BLOCK)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_i       (cfg_i.data),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_o       (rsp_o.data),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

// File: hw/rtl/pkba_ram.sv
// ----------------------------------------------------------------------------
// pkba_ram: simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pkba_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hw/rtl/pkba_ctrl.sv
// ----------------------------------------------------------------------------
// pkba_ctrl: allocator sequencer
// Walks one request through check, pop, drain or lookup steps and hands
// the result code to the datapath output register.
// ----------------------------------------------------------------------------
module pkba_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  pkba_pkg::stat_t stat_i,
  output pkba_pkg::cmd_t  cmd_o
);

  pkba_pkg::state_e   state_q, state_d;
  pkba_pkg::status_e  status_q, status_d;
  pkba_pkg::cnt_sel_e sel_q, sel_d;
  logic               lkres_q, lkres_d;
  logic               rb_q, rb_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pkba_pkg::ST_IDLE;
      status_q <= pkba_pkg::RS_OK;
      sel_q    <= pkba_pkg::CNT_ZERO;
      lkres_q  <= 1'b0;
      rb_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      sel_q    <= sel_d;
      lkres_q  <= lkres_d;
      rb_q     <= rb_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    sel_d       = sel_q;
    lkres_d     = lkres_q;
    rb_d        = rb_q;
    cmd_o       = '0;
    cmd_o.status  = status_q;
    cmd_o.cnt_sel = sel_q;
    cmd_o.lk_res  = lkres_q;
    req_ready_o = 1'b0;

    case (state_q)
      pkba_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = pkba_pkg::ST_CHECK;
        end
      end
      pkba_pkg::ST_CHECK: begin
        cmd_o.check = 1'b1;
        lkres_d     = 1'b0;
        sel_d       = pkba_pkg::CNT_ZERO;
        status_d    = pkba_pkg::RS_OK;
        state_d     = pkba_pkg::ST_FINISH;
        if (stat_i.bad_seq) begin
          status_d = pkba_pkg::RS_BAD_SEQ;
        end else begin
          case (stat_i.kind)
            pkba_pkg::KIND_ALLOC: begin
              if (stat_i.cnt_zero) state_d = pkba_pkg::ST_POP_RD;
              else status_d = pkba_pkg::RS_ALREADY;
            end
            pkba_pkg::KIND_APPEND: begin
              if (stat_i.cnt_zero) status_d = pkba_pkg::RS_NOT_ALLOC;
              else state_d = pkba_pkg::ST_POP_RD;
            end
            pkba_pkg::KIND_FREE: begin
              if (stat_i.cnt_zero) begin
                status_d = pkba_pkg::RS_NOT_ALLOC;
              end else begin
                rb_d    = 1'b0;
                state_d = pkba_pkg::ST_DRAIN_RD;
              end
            end
            default: begin
              sel_d = pkba_pkg::CNT_SEQ;
              if (stat_i.lk_ok) begin
                cmd_o.lk_rd = 1'b1;
                state_d     = pkba_pkg::ST_LK_MUL;
              end else begin
                status_d = pkba_pkg::RS_BAD_SLOT;
              end
            end
          endcase
        end
      end
      pkba_pkg::ST_POP_RD: begin
        if (stat_i.fill_done) begin
          cmd_o.cnt_wr = 1'b1;
          status_d     = pkba_pkg::RS_OK;
          sel_d        = (stat_i.kind == pkba_pkg::KIND_ALLOC) ? pkba_pkg::CNT_IDX
                                                               : pkba_pkg::CNT_ZERO;
          state_d      = pkba_pkg::ST_FINISH;
        end else if (stat_i.top_zero) begin
          // out of blocks: give back what this request took
          cmd_o.rb_init = 1'b1;
          rb_d          = 1'b1;
          state_d       = pkba_pkg::ST_DRAIN_RD;
        end else begin
          state_d = pkba_pkg::ST_POP_WR;
        end
      end
      pkba_pkg::ST_POP_WR: begin
        cmd_o.pop_wr = 1'b1;
        state_d      = pkba_pkg::ST_POP_RD;
      end
      pkba_pkg::ST_DRAIN_RD: begin
        cmd_o.drain_rd = 1'b1;
        if (stat_i.drain_done) begin
          sel_d   = pkba_pkg::CNT_ZERO;
          state_d = pkba_pkg::ST_FINISH;
          if (rb_q) begin
            status_d = pkba_pkg::RS_NO_BLOCKS;
          end else begin
            status_d          = pkba_pkg::RS_OK;
            cmd_o.cnt_wr      = 1'b1;
            cmd_o.cnt_wr_zero = 1'b1;
          end
        end else begin
          state_d = pkba_pkg::ST_DRAIN_WR;
        end
      end
      pkba_pkg::ST_DRAIN_WR: begin
        cmd_o.drain_wr = 1'b1;
        state_d        = pkba_pkg::ST_DRAIN_RD;
      end
      pkba_pkg::ST_LK_MUL: begin
        cmd_o.lk_mul = 1'b1;
        state_d      = pkba_pkg::ST_LK_ADD;
      end
      pkba_pkg::ST_LK_ADD: begin
        cmd_o.lk_add = 1'b1;
        status_d     = pkba_pkg::RS_OK;
        lkres_d      = 1'b1;
        state_d      = pkba_pkg::ST_FINISH;
      end
      pkba_pkg::ST_FINISH: begin
        if (!stat_i.out_busy) begin
          cmd_o.fin = 1'b1;
          state_d   = pkba_pkg::ST_IDLE;
        end
      end
      default: state_d = pkba_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/pkba_dp.sv
// ----------------------------------------------------------------------------
// pkba_dp: allocator datapath
// Free stack, slot table and count memories, walk counters, address
// arithmetic, configuration registers and the result register.
// ----------------------------------------------------------------------------
module pkba_dp #(
  parameter int NumSequences     = 16,
  parameter int SlotsPerSequence = 64,
  parameter int TotalBlocks      = 1024,
  parameter int TokensPerBlock   = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pkba_pkg::req_t  req_i,
  input  logic            cfg_valid_i,
  input  pkba_pkg::cfg_t  cfg_i,
  input  logic            rsp_ready_i,
  output logic            rsp_valid_o,
  output pkba_pkg::rsp_t  rsp_o,
  input  pkba_pkg::cmd_t  cmd_i,
  output pkba_pkg::stat_t stat_o
);

  localparam int SW   = (NumSequences > 1) ? $clog2(NumSequences) : 1;
  localparam int LW   = (SlotsPerSequence > 1) ? $clog2(SlotsPerSequence) : 1;
  localparam int CW   = $clog2(SlotsPerSequence + 1);
  localparam int NSL  = NumSequences * SlotsPerSequence;
  localparam int AW   = (NSL > 1) ? $clog2(NSL) : 1;
  localparam int BW   = (TotalBlocks > 1) ? $clog2(TotalBlocks) : 1;
  localparam int TW   = $clog2(TotalBlocks + 1);
  localparam int PW   = BW + pkba_pkg::BB_W;
  localparam int TKW  = pkba_pkg::TOK_W;
  localparam int CNTW = pkba_pkg::COUNT_W;
  localparam int PHW  = pkba_pkg::PHYS_W;
  localparam int ADW  = pkba_pkg::ADDR_W;
  localparam int SLW  = pkba_pkg::SLOT_W + 1;

  pkba_pkg::req_t    req_q;
  logic [CW-1:0]     cnt_q, idx_q, first_q, j_q, end_q;
  logic [TKW-1:0]    rem_q;
  logic [TW-1:0]     top_q, lwm_q;
  logic [BW-1:0]     phys_q;
  logic [PW-1:0]     prod_q;
  logic [ADW-1:0]    addr_q, kv_base_q;
  logic [pkba_pkg::BB_W-1:0] bb_q;
  logic [NumSequences-1:0]   cnt_vld_q;
  pkba_pkg::rsp_t    out_q;
  logic              out_vld_q;

  logic [SW-1:0]     seq_w;
  logic              bad_seq;
  logic [CW-1:0]     cnt_rdata, cnt_cur, cnt_wdata, cnt_out;
  logic [TW-1:0]     top_m1;
  logic [BW-1:0]     stack_rdata, slot_rdata, pop_blk;
  logic [AW-1:0]     slot_raddr, slot_waddr;
  logic              stack_we;

  function automatic logic [AW-1:0] slot_addr(logic [SW-1:0] s, logic [LW-1:0] l);
    slot_addr = AW'(s) * AW'(SlotsPerSequence) + AW'(l);
  endfunction

  assign bad_seq = ({1'b0, req_q.seq_id} >= SLW'(NumSequences));
  assign seq_w   = req_q.seq_id[SW-1:0];
  assign cnt_cur = (!bad_seq && cnt_vld_q[seq_w]) ? cnt_rdata : '0;
  assign top_m1  = top_q - TW'(1);
  // entries below the low-water mark were never written and hold their index
  assign pop_blk = (top_m1 < lwm_q) ? top_m1[BW-1:0] : stack_rdata;

  assign slot_raddr = cmd_i.drain_rd ? slot_addr(seq_w, j_q[LW-1:0])
                                     : slot_addr(seq_w, req_q.slot_index[LW-1:0]);
  assign slot_waddr = slot_addr(seq_w, idx_q[LW-1:0]);
  assign stack_we   = cmd_i.drain_wr && (top_q != TW'(TotalBlocks));
  assign cnt_wdata  = cmd_i.cnt_wr_zero ? '0 : idx_q;

  pkba_ram #(.Width(CW), .Depth(NumSequences)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.cnt_wr),
    .waddr_i (seq_w),
    .wdata_i (cnt_wdata),
    .raddr_i (req_i.seq_id[SW-1:0]),
    .rdata_o (cnt_rdata)
  );

  pkba_ram #(.Width(BW), .Depth(NSL)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.pop_wr),
    .waddr_i (slot_waddr),
    .wdata_i (pop_blk),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  pkba_ram #(.Width(BW), .Depth(TotalBlocks)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stack_we),
    .waddr_i (top_q[BW-1:0]),
    .wdata_i (slot_rdata),
    .raddr_i (top_m1[BW-1:0]),
    .rdata_o (stack_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q     <= TW'(TotalBlocks);
      lwm_q     <= TW'(TotalBlocks);
      cnt_vld_q <= '0;
      out_vld_q <= 1'b0;
      kv_base_q <= '0;
      bb_q      <= pkba_pkg::BLOCK_BYTES_RESET;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_i.index)
          pkba_pkg::REG_KV_BASE:     kv_base_q <= cfg_i.data;
          pkba_pkg::REG_BLOCK_BYTES: bb_q <= cfg_i.data[pkba_pkg::BB_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.pop_wr) begin
        top_q <= top_m1;
      end else if (stack_we) begin
        top_q <= top_q + TW'(1);
        if (top_q < lwm_q) lwm_q <= top_q;
      end
      if (cmd_i.cnt_wr) cnt_vld_q[seq_w] <= 1'b1;
      if (cmd_i.fin) out_vld_q <= 1'b1;
      else if (rsp_ready_i) out_vld_q <= 1'b0;
    end
  end

  // payload and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.check) begin
      cnt_q   <= cnt_cur;
      idx_q   <= (req_q.kind == pkba_pkg::KIND_APPEND) ? cnt_cur : '0;
      first_q <= (req_q.kind == pkba_pkg::KIND_APPEND) ? cnt_cur : '0;
      rem_q   <= req_q.tok_count;
      j_q     <= '0;
      end_q   <= cnt_cur;
    end
    if (cmd_i.rb_init) begin
      j_q   <= first_q;
      end_q <= idx_q;
    end
    if (cmd_i.pop_wr) begin
      idx_q <= idx_q + CW'(1);
      rem_q <= (rem_q > TKW'(TokensPerBlock)) ? rem_q - TKW'(TokensPerBlock) : '0;
    end
    if (cmd_i.drain_wr) j_q <= j_q + CW'(1);
    if (cmd_i.lk_mul) begin
      phys_q <= slot_rdata;
      prod_q <= PW'(slot_rdata) * PW'(bb_q);
    end
    if (cmd_i.lk_add) addr_q <= kv_base_q + ADW'(prod_q);
    if (cmd_i.fin) begin
      out_q.status        <= cmd_i.status;
      out_q.block_count   <= CNTW'(cnt_out);
      out_q.phys_block    <= cmd_i.lk_res ? PHW'(phys_q) : '0;
      out_q.block_address <= cmd_i.lk_res ? addr_q : '0;
    end
  end

  always_comb begin
    case (cmd_i.cnt_sel)
      pkba_pkg::CNT_IDX: cnt_out = idx_q;
      pkba_pkg::CNT_SEQ: cnt_out = cnt_q;
      default:           cnt_out = '0;
    endcase
  end

  assign stat_o.bad_seq    = bad_seq;
  assign stat_o.kind       = req_q.kind;
  assign stat_o.cnt_zero   = (cnt_cur == '0);
  assign stat_o.lk_ok      = ({1'b0, req_q.slot_index} < SLW'(SlotsPerSequence)) &&
                             ({1'b0, req_q.slot_index} < SLW'(cnt_cur));
  assign stat_o.fill_done  = (rem_q == '0) || (idx_q == CW'(SlotsPerSequence));
  assign stat_o.top_zero   = (top_q == '0);
  assign stat_o.drain_done = (j_q == end_q);
  assign stat_o.out_busy   = out_vld_q && !rsp_ready_i;

  assign rsp_valid_o = out_vld_q;
  assign rsp_o       = out_q;

endmodule

// File: tb/sv/pkba_alloc_checker.sv
// ----------------------------------------------------------------------------
// pkba_alloc_checker: result predictor and scoreboard for the block allocator
// Watches the request, result and register channels, keeps its own copy of
// the free stack, slot table and counts, and compares every result item.
// ----------------------------------------------------------------------------
module pkba_alloc_checker
  import pkba_pkg::*;
#(
  parameter int NUM_SEQUENCES      = 16,
  parameter int SLOTS_PER_SEQUENCE = 64,
  parameter int PHYS_BLOCKS        = 1024,
  parameter int TOKENS_PER_BLOCK   = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  logic req_ready_i,
  input  req_t req_data_i,
  input  logic rsp_valid_i,
  input  logic rsp_ready_i,
  input  rsp_t rsp_data_i,
  input  logic cfg_valid_i,
  input  logic cfg_ready_i,
  input  cfg_t cfg_data_i,
  output int   pending_o,
  output int   errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS = NUM_SEQUENCES * SLOTS_PER_SEQUENCE;

  logic [ADDR_W-1:0] kv_base;
  logic [BB_W-1:0]   blk_bytes;
  logic [PHYS_W-1:0] free_blocks [PHYS_BLOCKS];
  int                free_depth;
  logic [PHYS_W-1:0] slot_block [NUM_SLOTS];
  bit                slot_mapped [NUM_SLOTS];
  int                seq_blocks [NUM_SEQUENCES];
  rsp_t              expected_rsp [$];
  int                errors;
  int                reports;

  assign errors_o  = errors;

  function automatic int blocks_needed(longint unsigned tokens);
    longint unsigned b;
    b = (tokens + TOKENS_PER_BLOCK - 1) / TOKENS_PER_BLOCK;
    if (b > SLOTS_PER_SEQUENCE) b = SLOTS_PER_SEQUENCE;
    return int'(b);
  endfunction

  function automatic void push_free(logic [PHYS_W-1:0] blk);
    if (free_depth < PHYS_BLOCKS) begin
      free_blocks[free_depth] = blk;
      free_depth++;
    end
  endfunction

  // Map n slots starting at first; on empty stack undo in pop order.
  function automatic bit map_blocks(int s, int first, int n);
    int b;
    b = s * SLOTS_PER_SEQUENCE;
    for (int i = 0; i < n; i++) begin
      if (free_depth == 0) begin
        for (int j = 0; j < i; j++) begin
          push_free(slot_block[b + first + j]);
          slot_block[b + first + j]  = '0;
          slot_mapped[b + first + j] = 1'b0;
        end
        return 1'b0;
      end
      free_depth--;
      slot_block[b + first + i]  = free_blocks[free_depth];
      slot_mapped[b + first + i] = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic rsp_t serve_request(req_t r);
    rsp_t o;
    int   s, cur, total, b;
    o = '{status: RS_OK, default: '0};
    s = int'(r.seq_id);
    if (s >= NUM_SEQUENCES) begin
      o.status = RS_BAD_SEQ;
      return o;
    end
    cur = seq_blocks[s];
    b   = s * SLOTS_PER_SEQUENCE;
    case (r.kind)
      KIND_ALLOC: begin
        if (cur != 0) begin
          o.status = RS_ALREADY;
        end else begin
          total = blocks_needed(longint'(r.tok_count));
          if (map_blocks(s, 0, total)) begin
            seq_blocks[s] = total;
            o.block_count = COUNT_W'(total);
          end else begin
            o.status = RS_NO_BLOCKS;
          end
        end
      end
      KIND_APPEND: begin
        if (cur == 0) begin
          o.status = RS_NOT_ALLOC;
        end else begin
          total = blocks_needed(longint'(cur) * TOKENS_PER_BLOCK + longint'(r.tok_count));
          if (total > cur) begin
            if (map_blocks(s, cur, total - cur)) seq_blocks[s] = total;
            else o.status = RS_NO_BLOCKS;
          end
        end
      end
      KIND_FREE: begin
        if (cur == 0) begin
          o.status = RS_NOT_ALLOC;
        end else begin
          for (int i = 0; i < cur && i < SLOTS_PER_SEQUENCE; i++) begin
            if (slot_mapped[b + i]) begin
              push_free(slot_block[b + i]);
              slot_block[b + i]  = '0;
              slot_mapped[b + i] = 1'b0;
            end
          end
          seq_blocks[s] = 0;
        end
      end
      default: begin
        o.block_count = COUNT_W'(cur);
        if (int'(r.slot_index) >= SLOTS_PER_SEQUENCE || !slot_mapped[b + int'(r.slot_index)]) begin
          o.status = RS_BAD_SLOT;
        end else begin
          o.phys_block    = slot_block[b + int'(r.slot_index)];
          o.block_address = kv_base + ADDR_W'(o.phys_block) * ADDR_W'(blk_bytes);
        end
      end
    endcase
    return o;
  endfunction

  function automatic void flag(string what, logic [63:0] exp_v, logic [63:0] act_v);
    errors++;
    if (reports < 10) begin
      reports++;
      $display("mismatch %s: expected %0h actual %0h", what, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      kv_base    = '0;
      blk_bytes  = BLOCK_BYTES_RESET;
      free_depth = PHYS_BLOCKS;
      for (int i = 0; i < PHYS_BLOCKS; i++) free_blocks[i] = PHYS_W'(i);
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_block[i]  = '0;
        slot_mapped[i] = 1'b0;
      end
      for (int i = 0; i < NUM_SEQUENCES; i++) seq_blocks[i] = 0;
      expected_rsp.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_data_i.index == REG_KV_BASE) kv_base = cfg_data_i.data;
        else blk_bytes = cfg_data_i.data[BB_W-1:0];
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_rsp.size() == 0) begin
          flag("unexpected result item", 64'd0, 64'(rsp_data_i.status));
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_data_i.status !== want.status)
            flag("status", 64'(want.status), 64'(rsp_data_i.status));
          if (rsp_data_i.block_count !== want.block_count)
            flag("block_count", 64'(want.block_count), 64'(rsp_data_i.block_count));
          if (rsp_data_i.phys_block !== want.phys_block)
            flag("phys_block", 64'(want.phys_block), 64'(rsp_data_i.phys_block));
          if (rsp_data_i.block_address !== want.block_address)
            flag("block_address", want.block_address, rsp_data_i.block_address);
        end
      end
      if (req_valid_i && req_ready_i) expected_rsp.push_back(serve_request(req_data_i));
      pending_o = expected_rsp.size();
    end
  end

  initial begin
    errors  = 0;
    reports = 0;
  end

endmodule

// File: tb/sv/paged_kv_block_allocator_test.sv
// ----------------------------------------------------------------------------
// paged_kv_block_allocator_test: top of the allocator testbench
// Drives request and register items with random gaps and result stalls;
// the checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module paged_kv_block_allocator_test;
  import pkba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 5000000;
  localparam int ITEMS_PER_PHASE = 500;

  logic clk_i;
  logic rst_ni;
  int   tx_idle_pct;   // chance of a gap before a request item
  int   rx_idle_pct;   // chance of result ready low in a cycle
  int   cycles = 0;
  int   pending;
  int   errors;

  pkba_chan_if #(.T(req_t)) req_ch ();
  pkba_chan_if #(.T(rsp_t)) rsp_ch ();
  pkba_chan_if #(.T(cfg_t)) cfg_ch ();

  paged_kv_block_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch),
    .cfg_i  (cfg_ch)
  );

  pkba_alloc_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_ch.valid),
    .req_ready_i (req_ch.ready),
    .req_data_i  (req_ch.data),
    .rsp_valid_i (rsp_ch.valid),
    .rsp_ready_i (rsp_ch.ready),
    .rsp_data_i  (rsp_ch.data),
    .cfg_valid_i (cfg_ch.valid),
    .cfg_ready_i (cfg_ch.ready),
    .cfg_data_i  (cfg_ch.data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver stalls; re-drawn every cycle so stalls land on any phase.
  always @(posedge clk_i) begin
    if (!rst_ni) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // One request item: optional gap, then hold valid until the handshake.
  // Valid stays high after the accepting edge; the next call drives the next
  // item or a gap, and stop_req takes it down, so it is driven once per time step.
  // Ready only moves at rising edges, so sampling it at the falling edge
  // gives the value seen by the accepting edge.
  task automatic send_req(kind_e k, int s, int tok, int slot);
    req_t r;
    r.kind       = k;
    r.seq_id     = SEQ_W'(s);
    r.tok_count  = TOK_W'(tok);
    r.slot_index = SLOT_W'(slot);
    if ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(negedge clk_i); while (!req_ch.ready);
    @(posedge clk_i);
  endtask

  // Drop request valid and wait until every result has come back.
  task automatic stop_req();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Register writes only once every result has come back.
  task automatic write_reg(reg_e idx, logic [CFG_DATA_W-1:0] val);
    stop_req();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index: idx, data: val};
    do @(negedge clk_i); while (!cfg_ch.ready);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly valid sequences and small token counts, so that sequences get
  // allocated, grown, looked up and freed; the rest reaches every bit.
  task automatic random_phase(int n);
    kind_e k;
    int    s, tok, slot, pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 25) k = KIND_ALLOC;
      else if (pick < 50) k = KIND_APPEND;
      else if (pick < 65) k = KIND_FREE;
      else k = KIND_LOOKUP;
      s = ($urandom_range(99) < 92) ? $urandom_range(15) : $urandom_range(255);
      pick = $urandom_range(99);
      if (pick < 70) tok = $urandom_range(100);
      else if (pick < 90) tok = $urandom_range(1100);
      else tok = $urandom_range(1048575);
      slot = ($urandom_range(99) < 85) ? $urandom_range(63) : $urandom_range(255);
      send_req(k, s, tok, slot);
    end
  endtask

  initial begin
    tx_idle_pct  = 25;
    rx_idle_pct  = 48;
    rst_ni       = 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bad sequence for every kind, unallocated cases, zero and
    // maximal token counts, slot edges, lookups before and after free.
    send_req(KIND_ALLOC, 255, 5, 0);
    send_req(KIND_APPEND, 16, 5, 0);
    send_req(KIND_FREE, 128, 0, 0);
    send_req(KIND_LOOKUP, 16, 0, 0);
    send_req(KIND_APPEND, 0, 10, 0);
    send_req(KIND_FREE, 0, 0, 0);
    send_req(KIND_ALLOC, 0, 0, 0);
    send_req(KIND_LOOKUP, 0, 0, 0);
    send_req(KIND_ALLOC, 0, 1, 0);
    send_req(KIND_ALLOC, 0, 33, 0);
    send_req(KIND_APPEND, 0, 0, 0);
    send_req(KIND_APPEND, 0, 15, 0);
    send_req(KIND_LOOKUP, 0, 0, 0);
    send_req(KIND_APPEND, 0, 1048575, 0);
    send_req(KIND_LOOKUP, 0, 63, 255);
    send_req(KIND_LOOKUP, 0, 0, 64);
    send_req(KIND_LOOKUP, 0, 0, 255);
    send_req(KIND_LOOKUP, 5, 0, 0);
    send_req(KIND_ALLOC, 15, 1048575, 0);
    send_req(KIND_LOOKUP, 15, 0, 63);
    send_req(KIND_FREE, 0, 0, 0);
    send_req(KIND_LOOKUP, 0, 0, 1);
    send_req(KIND_FREE, 15, 0, 0);

    // Extreme settings, sender idling less than receiver.
    write_reg(REG_KV_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_BLOCK_BYTES, 64'h0000_0000_FFFF_FFFF);
    random_phase(ITEMS_PER_PHASE);

    // Block size of one byte, roles swapped.
    tx_idle_pct = 48;
    rx_idle_pct = 25;
    write_reg(REG_KV_BASE, 64'd0);
    write_reg(REG_BLOCK_BYTES, 64'd1);
    random_phase(ITEMS_PER_PHASE);

    // Random settings, no idling at all.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(REG_KV_BASE, {$urandom(), $urandom()});
    write_reg(REG_BLOCK_BYTES, {32'd0, $urandom()});
    random_phase(ITEMS_PER_PHASE);

    stop_req();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
